// ===== src/u2a_pkg.sv =====
// Package for the UTF-8 to ASCII transliterator: lead-byte codes, result types
// and the accent and symbol lookup tables. No dependencies.
package u2a_pkg;

  localparam logic [1:0] LEAD_NONE = 2'd0;
  localparam logic [1:0] LEAD_C3   = 2'd1;
  localparam logic [1:0] LEAD_C2   = 2'd2;

  localparam logic [7:0] BYTE_C3   = 8'hC3;
  localparam logic [7:0] BYTE_C2   = 8'hC2;
  localparam logic [6:0] CHAR_QMARK = 7'h3F;
  localparam logic [15:0] CAP_RESET = 16'd256;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  typedef struct packed {
    logic [6:0] ch;
    logic       is_end;
  } result_t;

  // beats pushed into the result queue for one accepted input beat
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic       keep;
    logic [6:0] ch;
  } sym_t;

  function automatic logic [6:0] map_accent(input logic [7:0] b);
    logic [6:0] r;
    r = CHAR_QMARK;
    case (b) inside
      [8'h80:8'h86]:         r = 7'h41; // A
      8'h87:                 r = 7'h43; // C
      [8'h88:8'h8B]:         r = 7'h45; // E
      [8'h8C:8'h8F]:         r = 7'h49; // I
      8'h91:                 r = 7'h4E; // N
      [8'h92:8'h96], 8'h98:  r = 7'h4F; // O
      [8'h99:8'h9C]:         r = 7'h55; // U
      8'h9D:                 r = 7'h59; // Y
      [8'hA0:8'hA6]:         r = 7'h61; // a
      8'hA7:                 r = 7'h63; // c
      [8'hA8:8'hAB]:         r = 7'h65; // e
      [8'hAC:8'hAF]:         r = 7'h69; // i
      8'hB1:                 r = 7'h6E; // n
      [8'hB2:8'hB6], 8'hB8:  r = 7'h6F; // o
      [8'hB9:8'hBC]:         r = 7'h75; // u
      8'hBD, 8'hBF:          r = 7'h79; // y
      default:               r = CHAR_QMARK;
    endcase
    return r;
  endfunction

  function automatic sym_t map_symbol(input logic [7:0] b);
    sym_t r;
    r.keep = 1'b1;
    r.ch   = CHAR_QMARK;
    case (b) inside
      8'hA1, 8'hBF: r.keep = 1'b0; // inverted marks dropped
      8'hA9:        r.ch = 7'h43;  // C
      8'hAE:        r.ch = 7'h52;  // R
      8'hB0:        r.ch = 7'h6F;  // o
      8'hB1:        r.ch = 7'h2B;  // +
      8'hB2:        r.ch = 7'h32;  // 2
      8'hB3:        r.ch = 7'h33;  // 3
      default:      r.ch = CHAR_QMARK;
    endcase
    return r;
  endfunction

endpackage

// ===== src/u2a_xlat.sv =====
// Byte decoder: lead-byte state, table lookup, capacity counter and end flag.
// Depends on u2a_pkg.
module u2a_xlat (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i,
  input  logic           accept_i,
  input  logic [7:0]     in_byte_i,
  input  logic           in_last_i,
  output u2a_pkg::push_t push_o
);
  import u2a_pkg::*;

  logic [15:0] cap_q, cnt_q, cnt_d;
  logic [1:0]  lead_q, lead_d;
  logic        done_q, done_d;
  logic        char_req, end_req, room, char_emit;
  logic [6:0]  char_val;
  sym_t        sym;

  assign room = ({1'b0, cnt_q} + 17'd1) < {1'b0, cap_q};
  assign sym  = map_symbol(in_byte_i);

  always_comb begin
    char_req = 1'b0;
    end_req  = 1'b0;
    char_val = CHAR_QMARK;
    lead_d   = LEAD_NONE;
    if (lead_q == LEAD_C3 || lead_q == LEAD_C2) begin
      if (in_byte_i == 8'd0) begin
        char_req = 1'b1;
        end_req  = 1'b1;
      end else if (lead_q == LEAD_C3) begin
        char_req = 1'b1;
        char_val = map_accent(in_byte_i);
      end else begin
        char_req = sym.keep;
        char_val = sym.ch;
      end
    end else begin
      if (in_byte_i == 8'd0) begin
        end_req = 1'b1;
      end else if (!in_byte_i[7]) begin
        char_req = 1'b1;
        char_val = in_byte_i[6:0];
      end else if (in_byte_i == BYTE_C3) begin
        lead_d = LEAD_C3;
      end else if (in_byte_i == BYTE_C2) begin
        lead_d = LEAD_C2;
      end else begin
        char_req = 1'b1;
      end
    end
    if (in_last_i && !end_req) begin
      if (lead_d != LEAD_NONE) begin
        lead_d   = LEAD_NONE;
        char_req = 1'b1;
        char_val = CHAR_QMARK;
      end
      end_req = 1'b1;
    end
  end

  assign char_emit = char_req && room && !done_q;

  always_comb begin
    push_o.first.ch      = char_emit ? char_val : 7'd0;
    push_o.first.is_end  = !char_emit;
    push_o.second.ch     = 7'd0;
    push_o.second.is_end = 1'b1;
    if (!accept_i || done_q) begin
      push_o.num = 2'd0;
    end else begin
      push_o.num = 2'(char_emit) + 2'(end_req);
    end
  end

  assign cnt_d  = cnt_q + 16'(char_emit);
  assign done_d = done_q | end_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_RESET;
      cnt_q  <= '0;
      lead_q <= LEAD_NONE;
      done_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept_i && !done_q) begin
        cnt_q  <= cnt_d;
        lead_q <= lead_d;
        done_q <= done_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_end_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !done_q && end_req |=> done_q)
    else $error("terminator pushed without closing the string");
  a_no_push_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> push_o.num == 2'd0)
    else $error("result pushed after end of string");
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && char_emit |-> ({1'b0, cnt_q} + 17'd1) < {1'b0, cap_q})
    else $error("character emitted beyond capacity");
`endif

endmodule

// ===== src/u2a_outq.sv =====
// Result queue: takes up to two result beats per cycle, hands out one per cycle while out_ready_i is high.
// Depends on u2a_pkg.
module u2a_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  u2a_pkg::push_t push_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [6:0]     out_char_o,
  output logic           out_end_o
);
  import u2a_pkg::*;

  result_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                pop;

  assign room_o      = cnt_q <= QCNT_W'(QDEPTH - 2);
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_char_o  = mem_q[rd_q].ch;
  assign out_end_o   = mem_q[rd_q].is_end;
  assign cnt_d       = cnt_q + QCNT_W'(push_i.num) - QCNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_q + QPTR_W'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPTR_W'(push_i.num);
      rd_q  <= rd_q + QPTR_W'(pop);
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cnt_q} + (QCNT_W+1)'(push_i.num)) <= (QCNT_W+1)'(QDEPTH))
    else $error("result queue overflow");
  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd0 |-> room_o)
    else $error("push while queue lacks room");
  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && push_i.num == 2'd0 |=> cnt_q == $past(cnt_q) - QCNT_W'(1))
    else $error("queue count mismatch on pop");
`endif

endmodule

// ===== src/utf8_to_ascii_transliterator.sv =====
// UTF-8 (Latin-1 subset) to 7-bit ASCII transliterator, top level.
// Depends on u2a_pkg, u2a_xlat and u2a_outq.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries one UTF-8 byte per beat with a
//   last flag. Output channel out_valid_o/out_ready_i carries one ASCII char
//   per beat; out_end_o marks the terminator beat (out_char_o is 0 then).
//   One input beat yields zero, one or two output beats.
//   Each result is written into the result queue when its input is taken.
//   Throughput: one input beat per cycle while each yields at most one result
//   and out_ready_i is high; the four-entry queue outputs one beat per cycle.
//   in_ready_o is high while the queue has room for two beats, so it does not
//   depend on out_ready_i in the same cycle.
//   cfg_we_i/cfg_wdata_i write out_capacity (buffer size incl. terminator)
//   with no wait; write only while idle.
//   Reset: capacity 256, no pending lead, count zero, queue empty.
//   After the terminator, further input beats are accepted and dropped until
//   the next reset. A stalled receiver fills the queue and then holds off input.
module utf8_to_ascii_transliterator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  out_char_o,
  output logic        out_end_o
);
  import u2a_pkg::*;

  push_t push;
  logic  accept;

  assign accept = in_valid_i && in_ready_o;

  u2a_xlat u_xlat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .push_o      (push)
  );

  u2a_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .out_end_o   (out_end_o)
  );

endmodule
